// ----- src/cnfa_pkg.sv -----
//------------------------------------------------------------------------------
// cnfa_pkg
// Shared types and constants of the circular next-fit allocator.
//------------------------------------------------------------------------------
package cnfa_pkg;

	localparam int unsigned MaxCells = 64;
	localparam int unsigned IdxW = $clog2(MaxCells);
	localparam int unsigned SizeW = IdxW + 1;
	localparam logic [7:0] FreeCell = 8'd48;
	localparam logic [7:0] LowerA = 8'd97;
	localparam logic [7:0] UpperA = 8'd65;
	localparam logic [7:0] Letters = 8'd26;

	localparam logic [1:0] CmdAlloc = 2'd0;
	localparam logic [1:0] CmdRelease = 2'd1;
	localparam logic [1:0] CmdDump = 2'd2;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StBadLen = 2'd1;
	localparam logic [1:0] StNoSpace = 2'd2;
	localparam logic [1:0] StNotFound = 2'd3;

	// datapath operations requested by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SEEK,
		OP_COMPACT,
		OP_FILL,
		OP_DUMP
	} op_t;

	typedef struct packed {
		op_t op;
		logic start; // first cycle of an operation: reset scan counters
		logic seek_free; // search for free cells, else for the label
		logic fill_free;
	} cmd_t;

	typedef struct packed {
		logic ready; // clearing pass after reset finished
		logic done; // current pass finished
		logic found;
		logic bad_len;
		logic [1:0] command;
		logic run_out; // a dump run is ready
		logic run_last;
	} stat_t;

endpackage

// ----- src/circular_next_fit_allocator.sv -----
//------------------------------------------------------------------------------
// circular_next_fit_allocator
// Next-fit cell allocator over a circular store of up to 64 owner bytes.
//------------------------------------------------------------------------------
// Usage: one input word per command on s_*; results leave on m_*.
// Allocate and release give one result word, dump gives one word per run
// with tlast on the final one. cfg_we/cfg_data set the store size; the
// user must set it only while idle, which the block does not enforce. Every
// pass scans one cell per cycle, but a dump pass stops at each run word
// until it is taken. An allocate searches, on a miss compacts and searches
// again, and fills a found run; a release searches and frees a found run.
// One command is handled at a time; the next word is accepted after the
// last result is taken. Reset sets the cursor to 0 and size to 64, then a
// clearing pass writes every cell free (48); s_tready stays low until it
// ends. If the receiver stalls, the result holds on m_tdata until taken.
//------------------------------------------------------------------------------
module circular_next_fit_allocator (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [6:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [17:0] s_tdata, // command[1:0], length[9:2], label[17:10]
	output logic m_tvalid,
	input logic m_tready,
	output logic [23:0] m_tdata, // status, start_index, run_length, run_label, zero
	output logic m_tlast
);

	cnfa_pkg::cmd_t cmd;
	cnfa_pkg::stat_t stat;
	logic [1:0] status;
	logic dump_word;
	logic [5:0] start_q;
	logic [6:0] run_len_q;
	logic [7:0] run_lab_q;

	cnfa_controller u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
		.status, .last(m_tlast), .dump_word, .cmd, .stat
	);

	cnfa_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_data,
		.in_command(s_tdata[1:0]), .in_length(s_tdata[9:2]), .in_label(s_tdata[17:10]),
		.cmd, .stat, .start_q, .run_len_q, .run_lab_q
	);

	// pack result word
	assign m_tdata = dump_word
		? {1'b0, run_lab_q, run_len_q, 6'd0, cnfa_pkg::StOk}
		: {1'b0, 8'd0, 7'd0, (status == cnfa_pkg::StOk) ? start_q : 6'd0, status};

endmodule

// ----- src/cnfa_datapath.sv -----
//------------------------------------------------------------------------------
// cnfa_datapath
// Cell store, cursor and the single-cell scan unit for seek, compact,
// fill and dump passes.
//------------------------------------------------------------------------------
module cnfa_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [6:0] cfg_data,
	input logic [1:0] in_command,
	input logic [7:0] in_length,
	input logic [7:0] in_label,
	input cnfa_pkg::cmd_t cmd,
	output cnfa_pkg::stat_t stat,
	output logic [5:0] start_q,
	output logic [6:0] run_len_q,
	output logic [7:0] run_lab_q
);

	logic [7:0] cells_q [cnfa_pkg::MaxCells];
	logic [7:0] rd_q;
	logic [cnfa_pkg::SizeW-1:0] size_q;
	logic [cnfa_pkg::IdxW-1:0] cursor_q, cursor_d;
	logic [1:0] cmd_q, cmd_d;
	logic [7:0] len_q, len_d, lab_q, lab_d;
	logic [cnfa_pkg::SizeW-1:0] n;
	logic [cnfa_pkg::IdxW-1:0] pos_q, pos_d, dst_q, dst_d;
	logic [cnfa_pkg::SizeW-1:0] i_q, i_d;
	logic [7:0] cnt_q, cnt_d;
	logic found_q, found_d, done_q, done_d;
	logic run_out_q, run_out_d, run_last_q, run_last_d;
	logic [cnfa_pkg::IdxW-1:0] start_d;
	logic [6:0] run_len_d;
	logic [7:0] run_lab_d;
	logic [cnfa_pkg::IdxW-1:0] clr_q;
	logic clearing_q;
	logic wr_en, mv_en;
	logic [cnfa_pkg::IdxW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic [7:0] cur, v;
	logic [cnfa_pkg::IdxW-1:0] pos_nx;
	logic [cnfa_pkg::SizeW-1:0] used;
	logic wrap, hit;
	logic [7:0] lab_up;

	// clamp size into range
	always_comb begin
		if (size_q == 7'd0) n = 7'd1;
		else if (size_q > 7'(cnfa_pkg::MaxCells)) n = 7'(cnfa_pkg::MaxCells);
		else n = size_q;
	end

	always_comb begin
		if (in_label >= cnfa_pkg::LowerA && in_label < cnfa_pkg::LowerA + cnfa_pkg::Letters)
			lab_up = in_label - cnfa_pkg::LowerA + cnfa_pkg::UpperA;
		else lab_up = in_label;
	end

	// registered read data holds the cell at pos_q
	assign cur = rd_q;
	assign v = cmd.seek_free ? cnfa_pkg::FreeCell : lab_q;
	assign wrap = ({1'b0, pos_q} + 7'd1) == n;
	assign pos_nx = wrap ? 6'd0 : pos_q + 6'd1;
	assign hit = (cur == v) && (cnt_q + 8'd1 == len_q);
	assign used = {1'b0, dst_q} + {6'd0, cur != cnfa_pkg::FreeCell};

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= 7'(cnfa_pkg::MaxCells);
		else if (cfg_we) size_q <= cfg_data;
	end

	// clearing pass after reset: one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 6'd1;
			clearing_q <= (clr_q != 6'(cnfa_pkg::MaxCells - 1));
		end
	end

	// cell store: two write ports for compaction moves, one registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			cells_q[clr_q] <= cnfa_pkg::FreeCell;
		end else begin
			if (wr_en) cells_q[wr_addr] <= wr_data;
			if (mv_en) cells_q[dst_q] <= cur;
		end
		rd_q <= cells_q[pos_d];
	end

	// scan unit: next values, one cell per cycle; a dump pass holds a cell while its run word goes out
	always_comb begin
		cursor_d = cursor_q;
		cmd_d = cmd_q;
		len_d = len_q;
		lab_d = lab_q;
		pos_d = pos_q;
		dst_d = dst_q;
		i_d = i_q;
		cnt_d = cnt_q;
		found_d = found_q;
		done_d = 1'b0;
		run_out_d = 1'b0;
		run_last_d = run_last_q;
		start_d = start_q;
		run_len_d = run_len_q;
		run_lab_d = run_lab_q;
		wr_en = 1'b0;
		mv_en = 1'b0;
		wr_addr = pos_q;
		wr_data = cnfa_pkg::FreeCell;
		case (cmd.op)
			cnfa_pkg::OP_LOAD: begin
				cmd_d = in_command;
				len_d = in_length;
				lab_d = lab_up;
				if ({1'b0, cursor_q} >= n) cursor_d = '0;
				found_d = 1'b0;
			end
			cnfa_pkg::OP_SEEK: begin
				if (cmd.start) begin
					pos_d = cursor_q;
					start_d = cursor_q;
					cnt_d = '0;
					i_d = '0;
					found_d = 1'b0;
				end else if (!done_q) begin
					pos_d = pos_nx;
					i_d = i_q + 7'd1;
					if (hit) begin
						found_d = 1'b1;
						done_d = 1'b1;
						cnt_d = cnt_q + 8'd1;
					end else if (wrap) begin
						// runs never continue across the wrap
						cnt_d = '0;
						start_d = '0;
					end else if (cur == v) begin
						cnt_d = cnt_q + 8'd1;
					end else begin
						cnt_d = '0;
						start_d = pos_nx;
					end
					if (!hit && i_q + 7'd1 == n) done_d = 1'b1;
				end
			end
			cnfa_pkg::OP_COMPACT: begin
				if (cmd.start) begin
					pos_d = '0;
					dst_d = '0;
					i_d = '0;
				end else if (!done_q) begin
					if (cur != cnfa_pkg::FreeCell) begin
						// move a used cell down, free its old place
						if (pos_q != dst_q) begin
							wr_en = 1'b1;
							mv_en = 1'b1;
						end
						dst_d = dst_q + 6'd1;
					end
					pos_d = pos_q + 6'd1;
					i_d = i_q + 7'd1;
					if (i_q + 7'd1 == n) begin
						done_d = 1'b1;
						cursor_d = (used >= n) ? 6'd0 : used[5:0];
					end
				end
			end
			cnfa_pkg::OP_FILL: begin
				if (cmd.start) begin
					pos_d = start_q;
					cnt_d = '0;
					cursor_d = start_q;
				end else if (!done_q) begin
					wr_en = 1'b1;
					wr_data = cmd.fill_free ? cnfa_pkg::FreeCell : lab_q;
					pos_d = pos_nx;
					cnt_d = cnt_q + 8'd1;
					if (cnt_q + 8'd1 == len_q) done_d = 1'b1;
				end
			end
			cnfa_pkg::OP_DUMP: begin
				if (cmd.start) begin
					pos_d = '0;
					i_d = '0;
					cnt_d = '0;
					run_last_d = 1'b0;
				end else if (!run_out_q) begin
					if (i_q < n) begin
						if (cnt_q == 8'd0) begin
							// open a run at the current cell
							run_lab_d = cur;
							cnt_d = 8'd1;
							pos_d = pos_q + 6'd1;
							i_d = i_q + 7'd1;
						end else if (cur == run_lab_q) begin
							cnt_d = cnt_q + 8'd1;
							pos_d = pos_q + 6'd1;
							i_d = i_q + 7'd1;
						end else begin
							// hold the differing cell for the next run
							run_len_d = cnt_q[6:0];
							cnt_d = '0;
							run_out_d = 1'b1;
							run_last_d = 1'b0;
						end
					end else if (cnt_q != 8'd0) begin
						run_len_d = cnt_q[6:0];
						cnt_d = '0;
						run_out_d = 1'b1;
						run_last_d = 1'b1;
						done_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			run_out_q <= 1'b0;
			run_last_q <= 1'b0;
			pos_q <= '0;
			i_q <= '0;
			cnt_q <= '0;
			dst_q <= '0;
			start_q <= '0;
			cmd_q <= '0;
			len_q <= '0;
			lab_q <= '0;
			run_len_q <= '0;
			run_lab_q <= '0;
		end else begin
			cursor_q <= cursor_d;
			done_q <= done_d;
			found_q <= found_d;
			run_out_q <= run_out_d;
			run_last_q <= run_last_d;
			pos_q <= pos_d;
			i_q <= i_d;
			cnt_q <= cnt_d;
			dst_q <= dst_d;
			start_q <= start_d;
			cmd_q <= cmd_d;
			len_q <= len_d;
			lab_q <= lab_d;
			run_len_q <= run_len_d;
			run_lab_q <= run_lab_d;
		end
	end

	assign stat.ready = !clearing_q;
	assign stat.done = done_q;
	assign stat.found = found_q;
	assign stat.bad_len = (len_q == 8'd0) || ({1'b0, len_q} > {2'b0, n});
	assign stat.command = cmd_q;
	assign stat.run_out = run_out_q;
	assign stat.run_last = run_last_q;

endmodule

// ----- src/cnfa_controller.sv -----
//------------------------------------------------------------------------------
// cnfa_controller
// Sequencer for allocate, release and dump, plus the output word register.
//------------------------------------------------------------------------------
module cnfa_controller (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input logic m_tready,
	output logic [1:0] status,
	output logic last,
	output logic dump_word,
	output cnfa_pkg::cmd_t cmd,
	input cnfa_pkg::stat_t stat
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_LOAD = 11'b00000000010,
		S_SEEK1 = 11'b00000000100,
		S_COMP = 11'b00000001000,
		S_SEEK2 = 11'b00000010000,
		S_FILL = 11'b00000100000,
		S_OUT = 11'b00001000000,
		S_DUMP = 11'b00010000000,
		S_DOUT = 11'b00100000000,
		S_DNEXT = 11'b01000000000,
		S_WAIT = 11'b10000000000
	} state_t;

	state_t state_q, nxt;
	logic first_q;
	logic [1:0] st_q;
	logic [1:0] st_d;
	logic last_q;

	assign s_tready = (state_q == S_IDLE) && stat.ready;
	assign m_tvalid = (state_q == S_OUT) || (state_q == S_DOUT);
	assign status = (state_q == S_DOUT) ? cnfa_pkg::StOk : st_q;
	assign last = (state_q == S_DOUT) ? last_q : 1'b1;
	assign dump_word = (state_q == S_DOUT);

	// next state and datapath command
	always_comb begin
		nxt = state_q;
		st_d = st_q;
		cmd = '{op: cnfa_pkg::OP_NONE, start: first_q, seek_free: 1'b0, fill_free: 1'b0};
		case (state_q)
			S_IDLE: if (s_tvalid && stat.ready) begin
				cmd.op = cnfa_pkg::OP_LOAD;
				nxt = S_LOAD;
			end
			S_LOAD: begin
				st_d = cnfa_pkg::StOk;
				if (stat.command == cnfa_pkg::CmdDump) nxt = S_DUMP;
				else if (!(stat.command inside {cnfa_pkg::CmdAlloc, cnfa_pkg::CmdRelease}))
					nxt = S_IDLE;
				else if (stat.bad_len) begin
					st_d = cnfa_pkg::StBadLen;
					nxt = S_OUT;
				end else nxt = S_SEEK1;
			end
			S_SEEK1: begin
				cmd.op = cnfa_pkg::OP_SEEK;
				cmd.seek_free = (stat.command == cnfa_pkg::CmdAlloc);
				if (!first_q && stat.done) begin
					if (stat.found) nxt = S_FILL;
					else if (stat.command == cnfa_pkg::CmdAlloc) nxt = S_COMP;
					else begin
						st_d = cnfa_pkg::StNotFound;
						nxt = S_OUT;
					end
				end
			end
			S_COMP: begin
				cmd.op = cnfa_pkg::OP_COMPACT;
				if (!first_q && stat.done) nxt = S_SEEK2;
			end
			S_SEEK2: begin
				cmd.op = cnfa_pkg::OP_SEEK;
				cmd.seek_free = 1'b1;
				if (!first_q && stat.done) begin
					if (stat.found) nxt = S_FILL;
					else begin
						st_d = cnfa_pkg::StNoSpace;
						nxt = S_OUT;
					end
				end
			end
			S_FILL: begin
				cmd.op = cnfa_pkg::OP_FILL;
				cmd.fill_free = (stat.command == cnfa_pkg::CmdRelease);
				if (!first_q && stat.done) nxt = S_OUT;
			end
			S_OUT: if (m_tready) nxt = S_IDLE;
			S_DUMP: begin
				cmd.op = cnfa_pkg::OP_DUMP;
				if (!first_q && stat.run_out) nxt = S_DOUT;
			end
			S_DOUT: if (m_tready) nxt = last_q ? S_WAIT : S_DNEXT;
			S_DNEXT: begin
				cmd.op = cnfa_pkg::OP_DUMP;
				cmd.start = 1'b0;
				nxt = S_DUMP;
			end
			S_WAIT: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	// state and pass-start flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
			st_q <= cnfa_pkg::StOk;
			last_q <= 1'b0;
		end else begin
			state_q <= nxt;
			st_q <= st_d;
			first_q <= ((nxt != state_q) && nxt != S_DUMP) || (state_q == S_LOAD);
			if (state_q == S_DUMP && stat.run_out) last_q <= stat.run_last;
		end
	end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular next-fit allocator. A queue-fed
// driver offers command words with random gaps. A behavioral model of the
// store predicts every result word, and the monitor checks each one in order.
// Store sizes change between phases while the block is idle.
//------------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] CmdIgnored = 2'd3;
	localparam int SettleCycles = 300;
	localparam int LongHold = 400;

	typedef struct packed {
		logic [7:0] label;
		logic [7:0] length;
		logic [1:0] command;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] start_index;
		logic [6:0] run_length;
		logic [7:0] run_label;
		logic last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [17:0] s_tdata = '0; // command[1:0], length[9:2], label[17:10]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata; // status[1:0], start_index[7:2], run_length[14:8], run_label[22:15]
	logic m_tlast;

	circular_next_fit_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// model of the store
	logic [7:0] store [cnfa_pkg::MaxCells];
	int unsigned cursor_pos;
	logic [6:0] size_reg;

	cmd_word_t pending_words [$];
	result_t expected_results [$];
	int errors = 0;
	int n_alloc = 0, n_release = 0, n_dump = 0, n_words_checked = 0;
	bit quiet = 1'b0;
	int hold_requests = 0;
	bit word_fired = 1'b0;

	function automatic int unsigned live_size();
		if (size_reg < 1) return 1;
		if (size_reg > cnfa_pkg::MaxCells) return cnfa_pkg::MaxCells;
		return size_reg;
	endfunction

	// next-fit search for a run of len cells equal to v, -1 if none
	function automatic int find_run(int unsigned n, int unsigned from, logic [7:0] v,
			int unsigned len);
		int unsigned pos, first, count;
		pos = (from < n) ? from : 0;
		first = pos;
		count = 0;
		for (int unsigned i = 0; i < n; i++) begin
			if (store[pos] == v) begin
				count++;
			end else begin
				count = 0;
				first = pos + 1;
				if (first == n) first = 0;
			end
			if (count == len) return first;
			pos++;
			if (pos == n) begin
				pos = 0;
				count = 0;
				first = 0;
			end
		end
		return -1;
	endfunction

	function automatic void paint(int unsigned n, int unsigned first, int unsigned len,
			logic [7:0] v);
		int unsigned k;
		for (int unsigned i = 0; i < len; i++) begin
			k = first + i;
			if (k >= n) k -= n;
			store[k] = v;
		end
	endfunction

	// squeeze used cells toward cell 0, return how many are used
	function automatic int unsigned squeeze(int unsigned n);
		int unsigned dst;
		logic [7:0] v;
		dst = 0;
		for (int unsigned i = 0; i < n; i++) begin
			if (store[i] != cnfa_pkg::FreeCell) begin
				v = store[i];
				store[i] = cnfa_pkg::FreeCell;
				store[dst] = v;
				dst++;
			end
		end
		return dst;
	endfunction

	// apply one accepted command word to the model and queue its results
	function automatic void predict_results(cmd_word_t w);
		int unsigned n, run, used;
		int found;
		logic [7:0] lab, v;
		result_t r;
		n = live_size();
		if (cursor_pos >= n) cursor_pos = 0;
		lab = w.label;
		if (lab >= cnfa_pkg::LowerA && lab < cnfa_pkg::LowerA + cnfa_pkg::Letters)
			lab = lab - cnfa_pkg::LowerA + cnfa_pkg::UpperA;
		r = '0;
		r.last = 1'b1;
		if (w.command == CmdIgnored) return;
		if (w.command == cnfa_pkg::CmdDump) begin
			n_dump++;
			v = store[0];
			run = 1;
			for (int unsigned i = 1; i <= n; i++) begin
				if (i < n && store[i] == v) begin
					run++;
					continue;
				end
				r.run_length = run[6:0];
				r.run_label = v;
				r.last = (i == n);
				expected_results.push_back(r);
				if (i < n) begin
					v = store[i];
					run = 1;
				end
			end
			return;
		end
		if (w.command == cnfa_pkg::CmdAlloc) n_alloc++;
		else n_release++;
		if (w.length == 0 || w.length > n) begin
			r.status = cnfa_pkg::StBadLen;
		end else if (w.command == cnfa_pkg::CmdAlloc) begin
			found = find_run(n, cursor_pos, cnfa_pkg::FreeCell, w.length);
			if (found < 0) begin
				used = squeeze(n);
				cursor_pos = (used >= n) ? 0 : used;
				found = find_run(n, cursor_pos, cnfa_pkg::FreeCell, w.length);
			end
			if (found < 0) begin
				r.status = cnfa_pkg::StNoSpace;
			end else begin
				r.start_index = found[5:0];
				paint(n, found, w.length, lab);
				cursor_pos = found;
			end
		end else begin
			found = find_run(n, cursor_pos, lab, w.length);
			if (found < 0) begin
				r.status = cnfa_pkg::StNotFound;
			end else begin
				r.start_index = found[5:0];
				paint(n, found, w.length, cnfa_pkg::FreeCell);
				cursor_pos = found;
			end
		end
		expected_results.push_back(r);
	endfunction

	// record handshakes and predict at the rising edge
	always @(posedge clk) begin
		word_fired = s_tvalid && s_tready;
		if (word_fired) predict_results(cmd_word_t'(s_tdata));
	end

	// driver: hold an unaccepted word, otherwise idle or send the next one
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !word_fired)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 10);
				s_tvalid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				s_tdata <= pending_words.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	int stall_left = 0;
	int holds_served = 0;
	always @(negedge clk) begin
		if (holds_served < hold_requests) begin
			holds_served++;
			stall_left = LongHold;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[1:0], m_tdata[7:2], m_tdata[14:8], m_tdata[22:15], m_tlast};
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word %h", $time, got);
			end else begin
				want = expected_results.pop_front();
				n_words_checked++;
				if (got.status !== want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.start_index !== want.start_index)
					$display("%0t: start_index exp %0d got %0d", $time,
						want.start_index, got.start_index);
				if (got.run_length !== want.run_length)
					$display("%0t: run_length exp %0d got %0d", $time,
						want.run_length, got.run_length);
				if (got.run_label !== want.run_label)
					$display("%0t: run_label exp %0d got %0d", $time,
						want.run_label, got.run_label);
				if (got.last !== want.last)
					$display("%0t: last exp %0d got %0d", $time, want.last, got.last);
				if (got !== want) errors++;
			end
		end
	end

	task automatic queue_word(logic [1:0] c, logic [7:0] len, logic [7:0] lab);
		cmd_word_t w;
		w.command = c;
		w.length = len;
		w.label = lab;
		pending_words.push_back(w);
	endtask

	// random mix: mostly allocates and releases over four labels in either case, some noise
	task automatic queue_random(int count, int unsigned max_len);
		int unsigned pick;
		logic [7:0] lab;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			lab = 8'(cnfa_pkg::UpperA + $urandom_range(0, 3) + ($urandom_range(0, 1) ? 32 : 0));
			if (pick < 45)
				queue_word(cnfa_pkg::CmdAlloc, 8'($urandom_range(1, max_len)), lab);
			else if (pick < 80)
				queue_word(cnfa_pkg::CmdRelease, 8'($urandom_range(1, max_len)), lab);
			else if (pick < 88)
				queue_word(cnfa_pkg::CmdDump, 8'($urandom), 8'($urandom));
			else if (pick < 90)
				queue_word(CmdIgnored, 8'($urandom), 8'($urandom));
			else
				queue_word(2'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !s_tvalid && expected_results.size() == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_size(logic [6:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		size_reg = value;
	endtask

	initial begin
		foreach (store[i]) store[i] = cnfa_pkg::FreeCell;
		cursor_pos = 0;
		size_reg = 7'(cnfa_pkg::MaxCells);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every command, letter bounds, free label
		queue_word(cnfa_pkg::CmdDump, 8'd0, 8'd0);
		queue_word(cnfa_pkg::CmdAlloc, 8'd0, 8'd65);
		queue_word(cnfa_pkg::CmdAlloc, 8'd65, 8'd65);
		queue_word(cnfa_pkg::CmdAlloc, 8'd255, 8'd255);
		queue_word(cnfa_pkg::CmdAlloc, 8'd3, 8'd97);
		queue_word(cnfa_pkg::CmdAlloc, 8'd2, 8'd122);
		queue_word(cnfa_pkg::CmdAlloc, 8'd2, 8'd123);
		queue_word(cnfa_pkg::CmdAlloc, 8'd1, 8'd96);
		queue_word(cnfa_pkg::CmdAlloc, 8'd2, 8'd255);
		queue_word(cnfa_pkg::CmdAlloc, 8'd1, 8'd0);
		queue_word(cnfa_pkg::CmdAlloc, 8'd4, cnfa_pkg::FreeCell);
		queue_word(cnfa_pkg::CmdRelease, 8'd4, cnfa_pkg::FreeCell);
		queue_word(cnfa_pkg::CmdRelease, 8'd3, 8'd97);
		queue_word(cnfa_pkg::CmdRelease, 8'd5, 8'd90);
		queue_word(cnfa_pkg::CmdRelease, 8'd0, 8'd90);
		queue_word(CmdIgnored, 8'd255, 8'd255);
		queue_word(cnfa_pkg::CmdDump, 8'd255, 8'd255);
		queue_word(cnfa_pkg::CmdAlloc, 8'd50, 8'd66);
		queue_word(cnfa_pkg::CmdAlloc, 8'd20, 8'd67);
		queue_word(cnfa_pkg::CmdAlloc, 8'd64, 8'd68);
		queue_word(cnfa_pkg::CmdRelease, 8'd2, 8'd122);
		queue_word(cnfa_pkg::CmdAlloc, 8'd8, 8'd69);
		queue_word(cnfa_pkg::CmdDump, 8'd1, 8'd1);
		drain();

		// phase at full size, with a long receiver hold-off
		hold_requests++;
		queue_random(90, 12);
		drain();

		set_size(7'd1);
		queue_random(40, 2);
		drain();

		set_size(7'd0);
		queue_random(30, 2);
		drain();

		set_size(7'd127);
		queue_random(90, 16);
		drain();

		set_size(7'd21);
		queue_random(90, 6);
		drain();

		// last stretch without any idling
		set_size(7'd64);
		quiet = 1'b1;
		queue_random(120, 10);
		drain();

		$display("Covered %0d allocates, %0d releases and %0d dumps over sizes 64, 1, 0, 127,",
			n_alloc, n_release, n_dump);
		$display("21 and 64, checking %0d result words.", n_words_checked);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("Timeout: %0d results still expected", expected_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
